FILE: sv/summed_area_box_window_macros.svh
// Assertion macros shared by the summed-area box window RTL.
`ifndef SUMMED_AREA_BOX_WINDOW_MACROS_SVH
`define SUMMED_AREA_BOX_WINDOW_MACROS_SVH

// Same-cycle implication, sampled on clock, switched off while in reset
`define SABW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, switched off while in reset
`define SABW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sabw_pkg.sv
// Shared constants, types and helpers of the summed-area box window block.
package sabw_pkg;

   // Grid and sample geometry
   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int SAMPLE_BITS = 16;

   localparam int ROW_BITS = $clog2(MAX_ROWS);
   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_BITS + COL_BITS;

   // Width for index arithmetic: holds a dimension, a centre plus radius, and a sign spare
   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DIM_LOG = $clog2(MAX_DIM + 1);
   localparam int IDX_W   = ((DIM_LOG > 9) ? DIM_LOG : 9) + 1;

   // Field and register widths
   localparam int SUM_W      = 33;
   localparam int MEAN_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int THR_W      = 16;
   localparam int RAD_W      = 8;
   localparam int DIM_W      = 9;
   localparam int POS_W      = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // Running column sum holds up to MAX_ROWS samples
   localparam int CRS_W = SAMPLE_BITS + ROW_BITS;

   // Window area and divider widths
   localparam int SIDE_W = RAD_W + 1;
   localparam int SQ_W   = 2 * SIDE_W;
   localparam int DIVD_W = SUM_W + FRAC_BITS;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BINARIZE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = CSR_IDX_W'(4);

   // Input function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Table write and read port bundles
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [SUM_W-1:0]  data;
   } tab_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tab_rd_type;

   // Divider request and response bundles
   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [SQ_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   // A dimension register of 0 acts as 1, above the maximum acts as the maximum
   function automatic logic [IDX_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [IDX_W-1:0] max_v);
      logic [IDX_W-1:0] ext;
      ext = IDX_W'(v);
      if (v == '0) begin
         return IDX_W'(1);
      end else if (ext > max_v) begin
         return max_v;
      end else begin
         return ext;
      end
   endfunction

endpackage

FILE: sv/summed_area_box_window.sv
// Top level of the summed-area box window block: sequencer, registers and result stage.
//
// Usage. Load transfers (func = 0) deliver samples in column-major order, row index
// fastest, over rows_used by cols_used; the block builds the summed-area table as they
// arrive. Query transfers (func = 1) name a centre cell and get one result transfer:
// the zero-padded box sum over radius, its Q16 mean, and the out_of_range / not_ready
// flags (sum and mean are zero when a flag is set).
// Sequence. A load passes through accept, table read of the left neighbour and table write.
// A query runs from accept to rsp_valid through corner reads over the single table read
// port, the divider start, the 49-step radix-2 divide and its finish, and the fill of the
// result register. A flagged query goes from accept straight to the result register.
// req_ready is high only while the sequencer is idle.
// Stall. A finished result waits in the result register while rsp_ready is low; loads
// carry on meanwhile, and a later query holds in its last step until the register frees.
// Reset. Registers take their defaults (binarize 1, threshold 0, radius 0, 256 by 256),
// loading restarts at (0,0) and the grid counts as not loaded. The table itself is not
// cleared and needs no clearing pass. Configuration writes take effect at once and must
// only come while the block is idle; a rows_used or cols_used write restarts loading.
`include "summed_area_box_window_macros.svh"

module summed_area_box_window
   import sabw_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // Configuration
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [POS_W-1:0]              req_row,
   input  logic [POS_W-1:0]              req_col,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SUM_W-1:0]       rsp_window_sum,
   output logic signed [MEAN_W-1:0]      rsp_window_mean_q16,
   output logic                          rsp_out_of_range,
   output logic                          rsp_not_ready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LD_RD,
      S_LD_WR,
      S_Q_RD,
      S_DIV_GO,
      S_DIV,
      S_OUT
   } state_type;

   // Corner read order of a query
   localparam logic [1:0] CORNER_BR = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_TL = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;
   localparam logic [2:0] CORNER_CNT_END = 3'd4;

   state_type         state_ff, state_in;

   // Configuration registers
   logic              binarize_ff, binarize_in;
   logic [THR_W-1:0]  threshold_ff, threshold_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [DIM_W-1:0]  rows_used_ff, rows_used_in;
   logic [DIM_W-1:0]  cols_used_ff, cols_used_in;

   // Load position state
   logic [ROW_BITS-1:0] load_row_ff, load_row_in;
   logic [COL_BITS-1:0] load_col_ff, load_col_in;
   logic [CRS_W-1:0]    crs_ff, crs_in;
   logic                grid_loaded_ff, grid_loaded_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          cnt_ff, cnt_in;

   // Item payload held while it is worked on
   logic [CRS_W-1:0]    v_ff, v_in;
   logic [ROW_BITS-1:0] imax_ff, imax_in;
   logic [COL_BITS-1:0] jmax_ff, jmax_in;
   logic [ROW_BITS-1:0] top_ff, top_in;
   logic [COL_BITS-1:0] left_ff, left_in;
   logic                top_v_ff, top_v_in;
   logic                left_v_ff, left_v_in;
   logic [SQ_W-1:0]     side_sq_ff, side_sq_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic                oor_ff, oor_in;
   logic                nr_ff, nr_in;

   // Result register
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                rsp_oor_ff, rsp_oor_in;
   logic                rsp_nr_ff, rsp_nr_in;

   tab_wr_type          tab_wr;
   tab_rd_type          tab_rd;
   logic [SUM_W-1:0]    tab_rd_data;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Combinational helpers
   logic [IDX_W-1:0]    ni, nj;
   logic [IDX_W-1:0]    i_w, j_w, rad_w;
   logic [IDX_W-1:0]    i_hi, j_hi;
   logic                restart;
   logic [CRS_W-1:0]    sample_ext, thr_ext;
   logic [CRS_W-1:0]    crs_new;
   logic [SUM_W-1:0]    left_term;
   logic [SUM_W-1:0]    acc_mag;
   logic [1:0]          acc_sel;
   logic                acc_use;
   logic [SIDE_W-1:0]   side;
   logic [MEAN_W-1:0]   q_low;

   sabw_table u_table (
      .clock   (clock),
      .wr      (tab_wr),
      .rd      (tab_rd),
      .rd_data (tab_rd_data)
   );

   sabw_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Effective geometry and query indexes
   assign ni    = clamp_dim(rows_used_ff, IDX_W'(MAX_ROWS));
   assign nj    = clamp_dim(cols_used_ff, IDX_W'(MAX_COLS));
   assign i_w   = IDX_W'(req_row);
   assign j_w   = IDX_W'(req_col);
   assign rad_w = IDX_W'(radius_ff);
   assign i_hi  = i_w + rad_w;
   assign j_hi  = j_w + rad_w;
   assign side  = {radius_ff, 1'b1};

   // Sample conditioning
   assign sample_ext = {{(CRS_W - SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}}, req_sample};
   assign thr_ext    = {{(CRS_W - THR_W){threshold_ff[THR_W-1]}}, threshold_ff};

   // Load position wraps after a finished grid or a geometry change
   assign restart = grid_loaded_ff || (IDX_W'(load_row_ff) >= ni)
                    || (IDX_W'(load_col_ff) >= nj);

   // Column running sum and left-neighbour term of a table entry
   assign crs_new   = ((load_row_ff == '0) ? '0 : crs_ff) + v_ff;
   assign left_term = (load_col_ff != '0) ? tab_rd_data : '0;

   // Corner accumulation: the corner whose data lands now is one behind the counter
   assign acc_sel = cnt_ff[1:0] - 2'd1;
   assign acc_mag = acc_ff[SUM_W-1] ? (~acc_ff + 1'b1) : acc_ff;
   assign q_low   = div_rsp.quotient[MEAN_W-1:0];

   always_comb begin
      case (acc_sel)
         CORNER_BR: acc_use = 1'b1;
         CORNER_TR: acc_use = top_v_ff;
         CORNER_TL: acc_use = top_v_ff && left_v_ff;
         CORNER_BL: acc_use = left_v_ff;
         default:   acc_use = 1'b0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      binarize_in    = binarize_ff;
      threshold_in   = threshold_ff;
      radius_in      = radius_ff;
      rows_used_in   = rows_used_ff;
      cols_used_in   = cols_used_ff;
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      crs_in         = crs_ff;
      grid_loaded_in = grid_loaded_ff;
      rsp_valid_in   = rsp_valid_ff;
      cnt_in         = cnt_ff;
      v_in           = v_ff;
      imax_in        = imax_ff;
      jmax_in        = jmax_ff;
      top_in         = top_ff;
      left_in        = left_ff;
      top_v_in       = top_v_ff;
      left_v_in      = left_v_ff;
      side_sq_in     = side_sq_ff;
      acc_in         = acc_ff;
      mean_in        = mean_ff;
      oor_in         = oor_ff;
      nr_in          = nr_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_oor_in     = rsp_oor_ff;
      rsp_nr_in      = rsp_nr_ff;
      tab_wr         = '0;
      tab_rd         = '0;
      div_req        = '0;

      // Result transfer frees the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  if (binarize_ff) begin
                     v_in = ($signed(sample_ext) >= $signed(thr_ext)) ? CRS_W'(1) : '0;
                  end else begin
                     v_in = sample_ext;
                  end
                  if (restart) begin
                     load_row_in = '0;
                     load_col_in = '0;
                     crs_in      = '0;
                  end
                  grid_loaded_in = 1'b0;
                  state_in       = S_LD_RD;
               end else begin
                  oor_in = (i_w >= ni) || (j_w >= nj);
                  nr_in  = !grid_loaded_ff;
                  acc_in  = '0;
                  mean_in = '0;
                  imax_in = (i_hi < ni - 1'b1) ? ROW_BITS'(i_hi) : ROW_BITS'(ni - 1'b1);
                  jmax_in = (j_hi < nj - 1'b1) ? COL_BITS'(j_hi) : COL_BITS'(nj - 1'b1);
                  top_in    = ROW_BITS'(i_w - rad_w - 1'b1);
                  left_in   = COL_BITS'(j_w - rad_w - 1'b1);
                  top_v_in  = i_w > rad_w;
                  left_v_in = j_w > rad_w;
                  side_sq_in = side * side;
                  cnt_in     = '0;
                  if ((i_w >= ni) || (j_w >= nj) || !grid_loaded_ff) begin
                     state_in = S_OUT;
                  end else begin
                     state_in = S_Q_RD;
                  end
               end
            end
         end

         S_LD_RD: begin
            tab_rd.en   = 1'b1;
            tab_rd.addr = {load_row_ff, load_col_ff - 1'b1};
            state_in    = S_LD_WR;
         end

         S_LD_WR: begin
            tab_wr.en   = 1'b1;
            tab_wr.addr = {load_row_ff, load_col_ff};
            tab_wr.data = {{(SUM_W - CRS_W){crs_new[CRS_W-1]}}, crs_new} + left_term;
            if (IDX_W'(load_row_ff) + 1'b1 >= ni) begin
               load_row_in = '0;
               crs_in      = '0;
               if (IDX_W'(load_col_ff) + 1'b1 >= nj) begin
                  load_col_in    = '0;
                  grid_loaded_in = 1'b1;
               end else begin
                  load_col_in = load_col_ff + 1'b1;
               end
            end else begin
               load_row_in = load_row_ff + 1'b1;
               crs_in      = crs_new;
            end
            state_in = S_IDLE;
         end

         S_Q_RD: begin
            // Issue the next corner read
            if (cnt_ff != CORNER_CNT_END) begin
               tab_rd.en = 1'b1;
               case (cnt_ff[1:0])
                  CORNER_BR: tab_rd.addr = {imax_ff, jmax_ff};
                  CORNER_TR: tab_rd.addr = {top_ff, jmax_ff};
                  CORNER_TL: tab_rd.addr = {top_ff, left_ff};
                  CORNER_BL: tab_rd.addr = {imax_ff, left_ff};
                  default:   tab_rd.addr = {imax_ff, jmax_ff};
               endcase
            end
            // Fold in the corner read a cycle ago; odd corners subtract
            if (cnt_ff != '0 && acc_use) begin
               if (acc_sel[0]) begin
                  acc_in = acc_ff - tab_rd_data;
               end else begin
                  acc_in = acc_ff + tab_rd_data;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CORNER_CNT_END) begin
               state_in = S_DIV_GO;
            end
         end

         S_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {acc_mag, {FRAC_BITS{1'b0}}};
            div_req.divisor  = side_sq_ff;
            state_in         = S_DIV;
         end

         S_DIV: begin
            if (div_rsp.done) begin
               mean_in  = acc_ff[SUM_W-1] ? (~q_low + 1'b1) : q_low;
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               rsp_mean_in  = mean_ff;
               rsp_oor_in   = oor_ff;
               rsp_nr_in    = nr_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Register writes; geometry changes restart loading
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BINARIZE:  binarize_in  = csr_wdata[0];
            CSR_THRESHOLD: threshold_in = csr_wdata[THR_W-1:0];
            CSR_RADIUS:    radius_in    = csr_wdata[RAD_W-1:0];
            CSR_ROWS_USED: begin
               rows_used_in   = csr_wdata[DIM_W-1:0];
               load_row_in    = '0;
               load_col_in    = '0;
               crs_in         = '0;
               grid_loaded_in = 1'b0;
            end
            CSR_COLS_USED: begin
               cols_used_in   = csr_wdata[DIM_W-1:0];
               load_row_in    = '0;
               load_col_in    = '0;
               crs_in         = '0;
               grid_loaded_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // State, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         binarize_ff    <= 1'b1;
         threshold_ff   <= '0;
         radius_ff      <= '0;
         rows_used_ff   <= DIM_W'(256);
         cols_used_ff   <= DIM_W'(256);
         load_row_ff    <= '0;
         load_col_ff    <= '0;
         crs_ff         <= '0;
         grid_loaded_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         binarize_ff    <= binarize_in;
         threshold_ff   <= threshold_in;
         radius_ff      <= radius_in;
         rows_used_ff   <= rows_used_in;
         cols_used_ff   <= cols_used_in;
         load_row_ff    <= load_row_in;
         load_col_ff    <= load_col_in;
         crs_ff         <= crs_in;
         grid_loaded_ff <= grid_loaded_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      imax_ff     <= imax_in;
      jmax_ff     <= jmax_in;
      top_ff      <= top_in;
      left_ff     <= left_in;
      top_v_ff    <= top_v_in;
      left_v_ff   <= left_v_in;
      side_sq_ff  <= side_sq_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      oor_ff      <= oor_in;
      nr_ff       <= nr_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_oor_ff  <= rsp_oor_in;
      rsp_nr_ff   <= rsp_nr_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window_sum      = rsp_sum_ff;
   assign rsp_window_mean_q16 = rsp_mean_ff;
   assign rsp_out_of_range    = rsp_oor_ff;
   assign rsp_not_ready       = rsp_nr_ff;

   // Every accepted item keeps the sequencer busy, so req_ready drops after an accept
   `SABW_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // The grid only becomes loaded through the final table write of a grid
   `SABW_ASSERT_IMP(a_loaded_from_write, $rose(grid_loaded_ff), $past(state_ff == S_LD_WR), "grid loaded without write")

   // Flagged results carry zero sum and mean
   `SABW_ASSERT_IMP(a_flag_zero, rsp_valid && (rsp_out_of_range || rsp_not_ready), (rsp_window_sum == '0) && (rsp_window_mean_q16 == '0), "flagged result not zero")

endmodule

FILE: sv/sabw_table.sv
// Summed-area table storage: one write port and one registered read port.
module sabw_table
   import sabw_pkg::*;
(
   input  logic             clock,
   input  tab_wr_type       wr,
   input  tab_rd_type       rd,
   output logic [SUM_W-1:0] rd_data
);

   logic [SUM_W-1:0] mem [2**ADDR_W];
   logic [SUM_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, data lands in the cycle after the request
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sabw_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sabw_divider
   import sabw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEP_W = $clog2(DIVD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]   den_ff, den_in;
   logic [DIVD_W-1:0] num_ff, num_in;

   logic [SQ_W:0] shifted;
   logic [SQ_W:0] trial;

   // One shift-subtract step; dividend bits leave at the top, quotient bits enter below
   always_comb begin
      shifted = {rem_ff, num_ff[DIVD_W-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = req.divisor;
         num_in  = req.dividend;
      end else if (busy_ff) begin
         if (!trial[SQ_W]) begin
            rem_in = trial[SQ_W-1:0];
            num_in = {num_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[SQ_W-1:0];
            num_in = {num_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

FILE: test/summed_area_box_window_tb.sv
// Self-checking testbench for the summed-area box window block: loads grids, queries windows.
module summed_area_box_window_tb
   import sabw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(7);
   localparam int SETTLE_CYCLES = 64;
   localparam int OP_TARGET     = 1600;
   localparam int MAX_PRINTS    = 100;

   typedef struct {
      logic                          func;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [POS_W-1:0]              row;
      logic [POS_W-1:0]              col;
   } grid_op_type;

   typedef struct {
      logic signed [SUM_W-1:0]  sum;
      logic signed [MEAN_W-1:0] mean;
      logic                     oor;
      logic                     nr;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index    = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata    = '0;
   logic                          req_valid    = 1'b0;
   logic                          req_ready;
   logic                          req_func     = FUNC_LOAD;
   logic signed [SAMPLE_BITS-1:0] req_sample   = '0;
   logic [POS_W-1:0]              req_row      = '0;
   logic [POS_W-1:0]              req_col      = '0;
   logic                          rsp_valid;
   logic                          rsp_ready    = 1'b0;
   logic signed [SUM_W-1:0]       rsp_window_sum;
   logic signed [MEAN_W-1:0]      rsp_window_mean_q16;
   logic                          rsp_out_of_range;
   logic                          rsp_not_ready;

   summed_area_box_window dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_sample          (req_sample),
      .req_row             (req_row),
      .req_col             (req_col),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_sum      (rsp_window_sum),
      .rsp_window_mean_q16 (rsp_window_mean_q16),
      .rsp_out_of_range    (rsp_out_of_range),
      .rsp_not_ready       (rsp_not_ready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the block: registers, fill position and the area table
   logic                    cfg_binarize;
   logic signed [THR_W-1:0] cfg_threshold;
   logic [RAD_W-1:0]        cfg_radius;
   logic [DIM_W-1:0]        cfg_rows;
   logic [DIM_W-1:0]        cfg_cols;
   longint                  sat_table [MAX_ROWS*MAX_COLS];
   int                      fill_row;
   int                      fill_col;
   longint                  col_acc;
   bit                      grid_done;

   grid_op_type       grid_ops [$];
   window_result_type expected_windows [$];
   grid_op_type       cur_op;
   int             ops_queued = 0;
   int             error_count = 0;
   int             send_gap = 0;
   int             hold_left = 0;
   bit             steady = 1'b0;

   function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic void restart_grid();
      fill_row  = 0;
      fill_col  = 0;
      col_acc   = 0;
      grid_done = 1'b0;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BINARIZE:  cfg_binarize  = data[0];
         CSR_THRESHOLD: cfg_threshold = data[THR_W-1:0];
         CSR_RADIUS:    cfg_radius    = data[RAD_W-1:0];
         CSR_ROWS_USED: begin
            cfg_rows = data[DIM_W-1:0];
            restart_grid();
         end
         CSR_COLS_USED: begin
            cfg_cols = data[DIM_W-1:0];
            restart_grid();
         end
         default: ;
      endcase
   endfunction

   // One sample into the table: column running sum plus the entry to the left
   function automatic void sat_load(logic signed [SAMPLE_BITS-1:0] s);
      int     ni, nj, r, c;
      longint v, left;
      ni = eff_dim(cfg_rows, MAX_ROWS);
      nj = eff_dim(cfg_cols, MAX_COLS);
      if (cfg_binarize) begin
         if (s >= cfg_threshold) v = 1;
         else v = 0;
      end else begin
         v = s;
      end
      if (grid_done) restart_grid();
      if (fill_row >= ni || fill_col >= nj) restart_grid();
      r = fill_row;
      c = fill_col;
      if (r == 0) col_acc = 0;
      col_acc = col_acc + v;
      left = 0;
      if (c > 0) left = sat_table[r*MAX_COLS + c - 1];
      sat_table[r*MAX_COLS + c] = col_acc + left;
      if (r + 1 >= ni) begin
         fill_row = 0;
         col_acc  = 0;
         if (c + 1 >= nj) begin
            fill_col  = 0;
            grid_done = 1'b1;
         end else begin
            fill_col = c + 1;
         end
      end else begin
         fill_row = r + 1;
      end
   endfunction

   // Window sum from four corners, zero padded, and its Q16 mean
   function automatic window_result_type sat_query(logic [POS_W-1:0] row,
                                                   logic [POS_W-1:0] col);
      window_result_type res;
      int     ni, nj, i, j, rad, imax, jmax;
      longint sum, side, quot;
      ni  = eff_dim(cfg_rows, MAX_ROWS);
      nj  = eff_dim(cfg_cols, MAX_COLS);
      i   = int'(row);
      j   = int'(col);
      rad = int'(cfg_radius);
      res.oor = (i >= ni) || (j >= nj);
      res.nr  = !grid_done;
      sum  = 0;
      quot = 0;
      if (!res.oor && !res.nr) begin
         imax = (i + rad < ni - 1) ? i + rad : ni - 1;
         jmax = (j + rad < nj - 1) ? j + rad : nj - 1;
         side = 2 * rad + 1;
         sum  = sat_table[imax*MAX_COLS + jmax];
         if (i > rad) begin
            sum = sum - sat_table[(i - rad - 1)*MAX_COLS + jmax];
            if (j > rad)
               sum = sum + sat_table[(i - rad - 1)*MAX_COLS + j - rad - 1]
                         - sat_table[imax*MAX_COLS + j - rad - 1];
         end else if (j > rad) begin
            sum = sum - sat_table[imax*MAX_COLS + j - rad - 1];
         end
         quot = (sum * 65536) / (side * side);
      end
      res.sum  = SUM_W'(sum);
      res.mean = MEAN_W'(quot);
      return res;
   endfunction

   // Idle lengths: mostly none or short, now and then long; none in a steady stretch
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_error(string msg);
      if (error_count < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Request driver: one transfer at a time from the backlog of grid operations
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (cur_op.func == FUNC_QUERY)
               expected_windows.push_back(sat_query(cur_op.row, cur_op.col));
            else
               sat_load(cur_op.sample);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (grid_ops.size() != 0) begin
               cur_op = grid_ops.pop_front();
               req_valid  <= 1'b1;
               req_func   <= cur_op.func;
               req_sample <= cur_op.sample;
               req_row    <= cur_op.row;
               req_col    <= cur_op.col;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random back-pressure, field by field check against the oldest window
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               flag_error($sformatf("result transfer with no query outstanding, sum %0d",
                                    rsp_window_sum));
            end else begin
               want = expected_windows.pop_front();
               if (rsp_window_sum !== want.sum)
                  flag_error($sformatf("window_sum %0d, wanted %0d", rsp_window_sum, want.sum));
               if (rsp_window_mean_q16 !== want.mean)
                  flag_error($sformatf("window_mean_q16 %0d, wanted %0d",
                                       rsp_window_mean_q16, want.mean));
               if (rsp_out_of_range !== want.oor)
                  flag_error($sformatf("out_of_range %b, wanted %b", rsp_out_of_range, want.oor));
               if (rsp_not_ready !== want.nr)
                  flag_error($sformatf("not_ready %b, wanted %b", rsp_not_ready, want.nr));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left = pick_gap();
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic void add_load(logic signed [SAMPLE_BITS-1:0] s);
      grid_op_type op;
      op.func   = FUNC_LOAD;
      op.sample = s;
      op.row    = POS_W'($urandom);
      op.col    = POS_W'($urandom);
      grid_ops.push_back(op);
      ops_queued++;
   endfunction

   function automatic void add_query(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
      grid_op_type op;
      op.func   = FUNC_QUERY;
      op.sample = SAMPLE_BITS'($urandom);
      op.row    = row;
      op.col    = col;
      grid_ops.push_back(op);
      ops_queued++;
   endfunction

   // Centre index: mostly inside the grid, edges favoured, sometimes anywhere
   function automatic logic [POS_W-1:0] pick_pos(int n);
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) return POS_W'($urandom_range(0, 255));
      if (r == 2) return '0;
      if (r == 3) return POS_W'(n - 1);
      return POS_W'($urandom_range(0, n - 1));
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3, 4: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
         5, 6: return cfg_threshold + SAMPLE_BITS'($urandom_range(0, 2) - 1);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic int pick_big_dim();
      case ($urandom_range(0, 2))
         0: return 256;
         1: return 511;
         default: return $urandom_range(257, 510);
      endcase
   endfunction

   // Wait for every transfer and result to drain, then let trailing loads finish
   task automatic wait_idle();
      do @(negedge clock);
      while (grid_ops.size() != 0 || req_valid || expected_windows.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One setting of the registers, one or two full grids with queries, maybe a partial reload
   task automatic random_phase(int shape);
      int rows_v, cols_v, ni, nj, cells, reps, nq, k;
      logic [CSR_DATA_W-1:0] junk;
      steady = ($urandom_range(0, 4) == 0);
      junk = CSR_DATA_W'($urandom);
      if (shape == 0) begin
         rows_v = pick_big_dim();
         cols_v = $urandom_range(1, 2);
      end else if (shape == 1) begin
         rows_v = $urandom_range(1, 2);
         cols_v = pick_big_dim();
      end else if (shape < 6) begin
         rows_v = $urandom_range(0, 24);
         cols_v = $urandom_range(0, 24);
      end else begin
         rows_v = $urandom_range(0, 8);
         cols_v = $urandom_range(0, 8);
      end
      if ($urandom_range(0, 1) == 0) csr_write(CSR_BINARIZE, CSR_DATA_W'($urandom));
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 4))
            0: csr_write(CSR_THRESHOLD, 16'h8000);
            1: csr_write(CSR_THRESHOLD, 16'h7FFF);
            2: csr_write(CSR_THRESHOLD, 16'h0000);
            default: csr_write(CSR_THRESHOLD, CSR_DATA_W'($urandom));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 9))
            0: csr_write(CSR_RADIUS, {junk[15:8], 8'd255});
            1: csr_write(CSR_RADIUS, {junk[15:8], 8'($urandom_range(0, 255))});
            default: csr_write(CSR_RADIUS, {junk[15:8], 8'($urandom_range(0, 3))});
         endcase
      end
      if (shape < 2 || $urandom_range(0, 2) != 0)
         csr_write(CSR_ROWS_USED, {junk[15:9], 9'(rows_v)});
      csr_write(CSR_COLS_USED, {junk[15:9], 9'(cols_v)});

      ni    = eff_dim(cfg_rows, MAX_ROWS);
      nj    = eff_dim(cfg_cols, MAX_COLS);
      cells = ni * nj;
      reps  = ($urandom_range(0, 3) == 0) ? 2 : 1;
      repeat (reps) begin
         for (k = 0; k < cells; k++) begin
            if ($urandom_range(0, 19) == 0) add_query(pick_pos(ni), pick_pos(nj));
            add_load(pick_sample());
         end
         nq = (cells > 64) ? $urandom_range(20, 40) : $urandom_range(3, 14);
         repeat (nq) add_query(pick_pos(ni), pick_pos(nj));
      end
      // Partial reload: a fresh grid begins, queries see it as not loaded unless the reload fills it
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, cells)) add_load(pick_sample());
         repeat (2) add_query(pick_pos(ni), pick_pos(nj));
      end
      wait_idle();
   endtask

   initial begin
      int phase_no;
      cfg_binarize  = 1'b1;
      cfg_threshold = '0;
      cfg_radius    = '0;
      cfg_rows      = DIM_W'(256);
      cfg_cols      = DIM_W'(256);
      restart_grid();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Queries before any grid: both not loaded, one at the far corner
      add_query(8'd0, 8'd0);
      add_query(8'd255, 8'd255);
      wait_idle();

      // Raw sums over a 3 by 2 grid with extreme samples, radius 1
      csr_write(CSR_BINARIZE, 16'h0000);
      csr_write(CSR_THRESHOLD, 16'hFFFF);
      csr_write(CSR_RADIUS, 16'h0001);
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      csr_write(CSR_ROWS_USED, 16'h0003);
      csr_write(CSR_COLS_USED, 16'h0002);
      add_load(16'sh7FFF);
      add_load(16'sh8000);
      add_load(-16'sd1);
      add_load(16'sd0);
      add_load(16'sd1);
      add_load(16'sh7FFF);
      add_query(8'd0, 8'd0);
      add_query(8'd1, 8'd1);
      add_query(8'd2, 8'd0);
      add_query(8'd3, 8'd1);
      add_query(8'd0, 8'd2);
      add_query(8'd255, 8'd255);
      // A load after a complete grid starts a new one
      add_load(16'sd5);
      add_query(8'd1, 8'd0);
      add_query(8'd9, 8'd9);
      wait_idle();

      // Threshold at the top, widest radius, a zero row count acting as one
      csr_write(CSR_BINARIZE, 16'h0001);
      csr_write(CSR_THRESHOLD, 16'h7FFF);
      csr_write(CSR_RADIUS, 16'h00FF);
      csr_write(CSR_ROWS_USED, 16'h0000);
      add_load(16'sh7FFF);
      add_load(16'sh7FFE);
      add_query(8'd0, 8'd0);
      add_query(8'd0, 8'd1);
      wait_idle();

      // Random part: the first two phases take the tall and the wide shapes
      phase_no = 0;
      while (ops_queued < OP_TARGET) begin
         random_phase((phase_no < 2) ? phase_no : $urandom_range(2, 39));
         phase_no++;
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/sabw_pkg.sv
sv/sabw_table.sv
sv/sabw_divider.sv
sv/summed_area_box_window.sv
test/summed_area_box_window_tb.sv
